### src/bounded_substring_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded substring search checker.
// All macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SUBSTRING_SEARCH_ASSERT_SVH
`define BOUNDED_SUBSTRING_SEARCH_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the bounded substring search block.
// ----------------------------------------------------------------------------
package sbs_pkg;

  // Pattern geometry
  localparam int MAX_PATTERN  = 8;
  localparam int RECENT_DEPTH = MAX_PATTERN - 1;
  localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
  localparam int VIEW_IDX_W   = $clog2(MAX_PATTERN);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int PAT_W    = 64;
  localparam int PLEN_W   = 4;
  localparam int WIN_W    = 16;
  localparam int CNT_W    = 17;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Register map, one register every eight bytes
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_WINDOW_LENGTH  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern_bytes;
    logic [PLEN_W-1:0] pattern_length;
    logic [WIN_W-1:0]  window_length;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [WIN_W-1:0] match_offset;
  } result_t;

endpackage

### src/sbs_cfg.sv
// ----------------------------------------------------------------------------
// sbs_cfg
// APB register file holding the pattern, its length and the window length.
// ----------------------------------------------------------------------------
module sbs_cfg
  import sbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t sel;
  logic     wr_en;

  assign sel    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_PATTERN_BYTES:  cfg_r.pattern_bytes  <= pwdata[PAT_W-1:0];
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= pwdata[PLEN_W-1:0];
        REG_WINDOW_LENGTH:  cfg_r.window_length  <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (sel)
      REG_PATTERN_BYTES:  prdata = DATA_W'(cfg_r.pattern_bytes);
      REG_PATTERN_LENGTH: prdata = DATA_W'(cfg_r.pattern_length);
      REG_WINDOW_LENGTH:  prdata = DATA_W'(cfg_r.window_length);
      default:            prdata = '0;
    endcase
  end

endmodule

### src/sbs_match.sv
// ----------------------------------------------------------------------------
// sbs_match
// Search state and the per-byte match check over all pattern positions.
// ----------------------------------------------------------------------------
module sbs_match
  import sbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              first_of_text,
  input  logic              last_of_text,
  output logic              res_valid,
  output result_t           res
);

  logic [BYTE_W-1:0]  recent_r   [RECENT_DEPTH];
  logic [BYTE_W-1:0]  recent_nxt [RECENT_DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               searching_r, searching_nxt;

  logic [BYTE_W-1:0]  view [MAX_PATTERN];
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   sel;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W:0]     idx_p1;
  logic [CNT_W:0]     start;
  logic [CNT_W:0]     win_ext;
  logic               reach;
  logic               in_win;
  logic               exhausted;
  logic               match;
  logic               active;

  // Clamp the pattern length
  assign len = (cfg.pattern_length > PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                           : LEN_W'(cfg.pattern_length);

  assign active = accept && (first_of_text || searching_r);

  // Byte window, newest first; a new search sees cleared history
  always_comb begin
    view[0] = text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      view[k] = first_of_text ? '0 : recent_r[k-1];
    end
  end

  // Offset bookkeeping
  assign idx       = first_of_text ? '0 : count_r;
  assign idx_p1    = {1'b0, idx} + (CNT_W+1)'(1);
  assign reach     = idx_p1 >= (CNT_W+1)'(len);
  assign start     = idx_p1 - (CNT_W+1)'(len);
  assign win_ext   = (CNT_W+1)'(cfg.window_length);
  assign in_win    = start < win_ext;
  assign exhausted = reach ? ((start + (CNT_W+1)'(1)) >= win_ext)
                           : (cfg.window_length == '0);

  // Compare every used pattern byte with its aligned text byte
  always_comb begin
    match = 1'b1;
    sel   = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) < len) begin
        sel = len - LEN_W'(1) - LEN_W'(j);
        if (view[sel[VIEW_IDX_W-1:0]] != cfg.pattern_bytes[BYTE_W*j +: BYTE_W]) begin
          match = 1'b0;
        end
      end
    end
  end

  // Decide the result for this byte
  always_comb begin
    res_valid        = 1'b0;
    res.found        = 1'b0;
    res.match_offset = '0;
    if (active) begin
      priority if (len == '0) begin
        res_valid = 1'b1;
        res.found = (cfg.window_length != '0);
      end else if (reach && in_win && match) begin
        res_valid        = 1'b1;
        res.found        = 1'b1;
        res.match_offset = start[WIN_W-1:0];
      end else if (exhausted || last_of_text) begin
        res_valid = 1'b1;
      end
    end
  end

  // Next search state
  always_comb begin
    searching_nxt = searching_r;
    count_nxt     = count_r;
    for (int k = 0; k < RECENT_DEPTH; k++) begin
      recent_nxt[k] = recent_r[k];
    end
    if (active) begin
      searching_nxt = !res_valid;
      count_nxt     = (idx < COUNT_MAX) ? idx + CNT_W'(1) : idx;
      recent_nxt[0] = text_byte;
      for (int k = 1; k < RECENT_DEPTH; k++) begin
        recent_nxt[k] = view[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r <= 1'b0;
      count_r     <= '0;
      for (int k = 0; k < RECENT_DEPTH; k++) begin
        recent_r[k] <= '0;
      end
    end else begin
      searching_r <= searching_nxt;
      count_r     <= count_nxt;
      for (int k = 0; k < RECENT_DEPTH; k++) begin
        recent_r[k] <= recent_nxt[k];
      end
    end
  end

endmodule

### src/sbs_out_buf.sv
// ----------------------------------------------------------------------------
// sbs_out_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module sbs_out_buf
  import sbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic [1:0] count_r, count_nxt;
  result_t    head_r, head_nxt;
  result_t    skid_r, skid_nxt;
  logic       pop;

  assign pop       = (count_r != 2'd0) && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;

  // Advance the head, park a result in the skid entry when the head holds
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    unique case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt  = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = skid_r;
          count_nxt = 2'd1;
        end
      end
      default: count_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### src/bounded_substring_search.sv
// ----------------------------------------------------------------------------
// bounded_substring_search
// Streams text bytes and reports the first in-window offset of a pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Program pattern_bytes (0x00), pattern_length (0x08) and window_length
//   (0x10) over the APB port while the block is idle. Then send text bytes
//   on the in_ channel, one per transfer, with in_first_of_text on the first
//   byte of each search and in_last_of_text on the final available byte.
//   Each search gives exactly one out_ transfer, found with the start offset
//   or not found with offset zero, unless a new in_first_of_text drops it.
// Throughput and result path:
//   One byte is taken every cycle while in_stall is low; all pattern
//   positions are compared in parallel against the stored recent bytes. A
//   result is registered in the result buffer before it shows on out_valid.
// Stall:
//   Results wait in a two-entry buffer. in_stall rises only when both
//   entries are occupied, so input keeps flowing through one stalled result.
// Reset:
//   rst_n (synchronous, active low) clears the registers, the search state
//   and the result buffer.
// ----------------------------------------------------------------------------
module bounded_substring_search
  import sbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Text input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_first_of_text,
  input  logic              in_last_of_text,
  // Result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [WIN_W-1:0]  out_match_offset,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  sbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbs_match u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .accept        (accept),
    .text_byte     (in_text_byte),
    .first_of_text (in_first_of_text),
    .last_of_text  (in_last_of_text),
    .res_valid     (res_valid),
    .res           (res)
  );

  sbs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_found        = out_data.found;
  assign out_match_offset = out_data.match_offset;

endmodule

### src/sbs_checker.sv
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks for the bounded substring search, bound to the top.
// ----------------------------------------------------------------------------
`include "bounded_substring_search_assert.svh"

module sbs_checker
  import sbs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_found,
  input logic [WIN_W-1:0] out_match_offset
);

  logic           out_miss;
  logic           out_held;
  logic [WIN_W:0] out_word;

  assign out_miss = out_valid && !out_found;
  assign out_held = out_valid && out_stall;
  assign out_word = {out_found, out_match_offset};

  // A not-found result carries offset zero
  `SBS_ASSERT_NOW(a_offset_zero_on_miss, out_miss, out_match_offset == '0, "offset set on a miss")

  // Input only holds back while a result is pending at the output
  `SBS_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid, "input stalled with no result")

  // A stalled result holds its value
  `SBS_ASSERT_NEXT(a_result_holds, out_held, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind bounded_substring_search sbs_checker u_sbs_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded substring search block. Text bytes go
// in over the valid/stall input channel and the pattern and window are
// programmed over the APB port. A predictor in the bench tracks the search
// state and queues the answer that each byte decides. The result channel is
// compared field by field against that queue. Directed searches cover the
// corner cases, then random searches with random settings run, first with no
// gaps and then with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 8;
  localparam int MAX_REPORTS   = 10;

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_text_byte     = '0;
  logic              in_first_of_text = 1'b0;
  logic              in_last_of_text  = 1'b0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic              out_found;
  logic [WIN_W-1:0]  out_match_offset;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [ADDR_W-1:0] paddr            = '0;
  logic [DATA_W-1:0] pwdata           = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predictor state: register copy and search progress
  cfg_t              search_cfg      = '0;
  logic [BYTE_W-1:0] seen_bytes [RECENT_DEPTH];
  logic [CNT_W-1:0]  seen_count      = '0;
  logic              in_search       = 1'b0;
  result_t           expected_answers[$];

  int                mismatches      = 0;
  int                bytes_taken     = 0;
  int                cycles          = 0;
  bit                in_idle_on      = 1'b1;
  bit                out_idle_on     = 1'b1;

  // Per-phase stimulus choices
  logic [BYTE_W-1:0] alphabet [4];
  logic [PAT_W-1:0]  phase_pattern;
  int                phase_len;

  bounded_substring_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_first_of_text (in_first_of_text),
    .in_last_of_text  (in_last_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Advance the search state by one accepted byte; queue the answer if decided
  function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic is_first,
                                       input logic is_last);
    logic [BYTE_W-1:0] view [MAX_PATTERN];
    int unsigned       len;
    int unsigned       idx;
    int unsigned       start;
    int unsigned       next_start;
    logic              hit;
    logic              decided;
    result_t           ans;
    if (is_first) begin
      in_search  = 1'b1;
      seen_count = '0;
      foreach (seen_bytes[k]) seen_bytes[k] = '0;
    end
    if (!in_search) return;
    bytes_taken++;
    len = (search_cfg.pattern_length > MAX_PATTERN) ? MAX_PATTERN
                                                     : search_cfg.pattern_length;
    idx = 32'(seen_count);
    if (seen_count != COUNT_MAX) seen_count = seen_count + 1'b1;
    // view[k] is the byte k positions back from this one
    view[0] = b;
    for (int k = 1; k < MAX_PATTERN; k++) view[k] = seen_bytes[k-1];
    for (int k = RECENT_DEPTH - 1; k > 0; k--) seen_bytes[k] = seen_bytes[k-1];
    seen_bytes[0] = b;

    decided = 1'b0;
    ans     = '0;
    if (len == 0) begin
      decided   = 1'b1;
      ans.found = (search_cfg.window_length != 0);
    end else begin
      if (idx + 1 >= len) begin
        start = idx + 1 - len;
        if (start < search_cfg.window_length) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (view[len-1-j] != search_cfg.pattern_bytes[8*j +: 8]) hit = 1'b0;
          end
          if (hit) begin
            decided          = 1'b1;
            ans.found        = 1'b1;
            ans.match_offset = start[WIN_W-1:0];
          end
        end
        next_start = start + 1;
      end else begin
        next_start = 0;
      end
      // Out of offsets or out of text
      if (!decided && (next_start >= search_cfg.window_length || is_last)) decided = 1'b1;
    end
    if (decided) begin
      in_search = 1'b0;
      expected_answers.push_back(ans);
    end
  endfunction

  function automatic void flag_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected found=%0b offset=%0d, got found=%0b offset=%0d",
               $time, what, want.found, want.match_offset, got.found, got.match_offset);
  endfunction

  function automatic void check_reg(input string what, input logic [DATA_W-1:0] want,
                                    input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s readback: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Track register writes and input transfers, check each result transfer
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_PATTERN_BYTES:  search_cfg.pattern_bytes  = pwdata[PAT_W-1:0];
          REG_PATTERN_LENGTH: search_cfg.pattern_length = pwdata[PLEN_W-1:0];
          REG_WINDOW_LENGTH:  search_cfg.window_length  = pwdata[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_byte(in_text_byte, in_first_of_text, in_last_of_text);
      if (out_valid && !out_stall) begin
        got.found        = out_found;
        got.match_offset = out_match_offset;
        if (expected_answers.size() == 0) begin
          flag_mismatch("result with no answer pending", '0, got);
        end else begin
          want = expected_answers.pop_front();
          if (got.found !== want.found) flag_mismatch("found", want, got);
          if (got.match_offset !== want.match_offset) flag_mismatch("match_offset", want, got);
        end
      end
    end
    out_stall <= out_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Send one text byte; returns at the edge that takes it, valid still high
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_first,
                           input logic is_last);
    while (in_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_text_byte     <= b;
    in_first_of_text <= is_first;
    in_last_of_text  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold input until every pending answer has come out
  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_answers.size() != 0);
    repeat (extra + 1) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Read one register; the value is taken at the access edge
  task automatic read_reg(input reg_idx_t r, output logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic program_search(input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] plen,
                                input logic [WIN_W-1:0] win);
    wait_drained(SETTLE_CYCLES);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, DATA_W'(plen));
    write_reg(REG_WINDOW_LENGTH, DATA_W'(win));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One search: random text over the phase alphabet, often holding the pattern
  task automatic send_search();
    logic [BYTE_W-1:0] text[$];
    int                n;
    int                p;
    logic              f;
    logic              l;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 16);
    for (int i = 0; i < n; i++)
      text.push_back(($urandom_range(0, 3) != 0) ? alphabet[$urandom_range(0, 3)]
                                                  : BYTE_W'($urandom));
    if (phase_len > 0 && n >= phase_len && $urandom_range(0, 9) < 6) begin
      p = $urandom_range(0, n - phase_len);
      for (int j = 0; j < phase_len; j++) text[p+j] = phase_pattern[8*j +: 8];
    end
    for (int i = 0; i < n; i++) begin
      f = (i == 0) || ($urandom_range(0, 99) < 3);
      l = (i == n - 1) && ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 199) == 0) wait_drained(0);
      send_byte(text[i], f, l);
    end
    // Trailing bytes with no start marker
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  // Random settings, a few searches each, until enough bytes were searched
  task automatic run_random_phases(input int target);
    int               base;
    logic [PLEN_W-1:0] plen;
    logic [WIN_W-1:0]  win;
    base = bytes_taken;
    while (bytes_taken - base < target) begin
      foreach (alphabet[k]) alphabet[k] = BYTE_W'($urandom);
      case ($urandom_range(0, 9))
        0:       plen = '0;
        1:       plen = PLEN_W'($urandom_range(MAX_PATTERN + 1, 15));
        default: plen = PLEN_W'($urandom_range(1, MAX_PATTERN));
      endcase
      case ($urandom_range(0, 9))
        0:       win = '0;
        1:       win = '1;
        2:       win = WIN_W'($urandom);
        default: win = WIN_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 19))
        0:       phase_pattern = '0;
        1:       phase_pattern = '1;
        default: begin
          for (int j = 0; j < MAX_PATTERN; j++)
            phase_pattern[8*j +: 8] = ($urandom_range(0, 9) < 7) ? alphabet[$urandom_range(0, 3)]
                                                                   : BYTE_W'($urandom);
        end
      endcase
      phase_len = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      program_search(phase_pattern, plen, win);
      repeat ($urandom_range(3, 8)) send_search();
      // Close any open search so the next setup starts idle
      send_byte(BYTE_W'($urandom), 1'b1, 1'b1);
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'hA5, 1'b0, 1'b0);      // ignored while idle
    send_byte(8'h00, 1'b1, 1'b0);      // empty pattern, empty window
    program_search('1, 4'd0, 16'd1);
    send_byte(8'hFF, 1'b1, 1'b1);      // empty pattern matches at zero
  endtask

  task automatic test_directed_cases();
    // Pattern FF 00, three start offsets
    program_search(64'h0000_0000_0000_00FF, 4'd2, 16'd3);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // Window used up
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0);
    // Text ends before a full pattern
    send_byte(8'h11, 1'b1, 1'b1);
    // Restart drops the open search
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // Length above the maximum clamps to eight; pause mid-search until drained
    program_search(64'h8877_6655_4433_2211, 4'd15, 16'hFFFF);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0);
    wait_drained(0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'h66, 1'b0, 1'b0);
    send_byte(8'h77, 1'b0, 1'b0);
    send_byte(8'h88, 1'b0, 1'b0);
    // Empty window with a real pattern
    program_search(64'h0000_0000_0000_5A5A, 4'd2, 16'd0);
    send_byte(8'h5A, 1'b1, 1'b0);
  endtask

  task automatic test_register_readback();
    logic [DATA_W-1:0] rd;
    program_search(64'hC3A5_0F1E_7D2B_9846, 4'd5, 16'h1234);
    read_reg(REG_PATTERN_BYTES, rd);
    check_reg("pattern_bytes", 64'hC3A5_0F1E_7D2B_9846, rd);
    read_reg(REG_PATTERN_LENGTH, rd);
    check_reg("pattern_length", 64'd5, rd);
    read_reg(REG_WINDOW_LENGTH, rd);
    check_reg("window_length", 64'h1234, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_back_to_back();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_random_phases(300);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_searches();
    run_random_phases(1500);
  endtask

  initial begin
    foreach (seen_bytes[k]) seen_bytes[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_register_readback();
    test_back_to_back();
    test_random_searches();
    wait_drained(SETTLE_CYCLES);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
